// ===== design/wfc_pkg.sv =====
package wfc_pkg;

    // table geometry
    localparam int ENTRIES     = 16;
    localparam int WORD_LEN    = 32;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int SCNT_W    = $clog2(ENTRIES + 1);
    localparam int LEN_W     = 6;
    localparam int CNT_W     = 16;
    localparam int ROWS      = ENTRIES + 1;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int MEM_DEPTH = ROWS * WORD_LEN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int BUF_ROW   = ENTRIES;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // configuration register indexes
    localparam logic [7:0] CFG_MIN_LENGTH = 8'd0;
    localparam logic [7:0] CFG_MIN_COUNT  = 8'd1;

    typedef enum logic [2:0] {
        OP_CHAR   = 3'd0,
        OP_END    = 3'd1,
        OP_REPORT = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRD,
        ST_SCHK,
        ST_CPRD,
        ST_CPWR,
        ST_SORT_OUT,
        ST_SCMP,
        ST_CRD,
        ST_CCHK,
        ST_RPT,
        ST_RFIN,
        ST_RDOUT
    } state_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic [3:0] rank_in;
        logic [4:0] position;
    } in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       rank;
        logic [CNT_W-1:0] count;
        logic [LEN_W-1:0] word_length;
        logic [7:0]       char_out;
        logic             last;
    } out_t;

    // byte address of one character in the word memory
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [ROW_W-1:0] row,
                                                   input logic [LEN_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(WORD_LEN);
        return ADDR_W'(base + ADDR_W'(pos));
    endfunction

endpackage

// ===== design/word_frequency_counter_top.sv =====
// Word frequency counter. Characters, word ends, report, read and clear
// commands enter on the s_ channel; results leave on the m_ channel, one
// result register deep. Words live in one byte-wide memory with two read
// ports (one row per table slot plus one row for the word being built);
// counts, lengths, slot flags and the rank order sit in flip-flops. A
// character or clear is handled in ST_IDLE. A word end is accepted, then the
// slots are scanned (plus a closing step when no slot matches); each byte
// compared against a slot of equal length takes a read and a check state, and
// a new word is copied in the same way. A report runs an insertion sort: each
// of the ENTRIES-1 keys is picked up, then up to ENTRIES*(ENTRIES-1)/2
// comparisons are made in all, each a compare state plus a read and a check
// state per byte compared; the ranks are then emitted plus a final result,
// held while the receiver stalls. Read and check states come from the
// registered memory reads. Configuration writes are taken at any time.
module word_frequency_counter_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  wfc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output wfc_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import wfc_pkg::*;

    state_t state_reg, state_next;

    logic [LEN_W-1:0] min_len_reg;
    logic [CNT_W-1:0] min_cnt_reg;

    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [SCNT_W-1:0] slot_reg, slot_next;
    logic [SCNT_W-1:0] free_reg, free_next;
    logic [SCNT_W-1:0] i_reg, i_next;
    logic [SCNT_W-1:0] j_reg, j_next;
    logic [SLOT_W-1:0] key_reg, key_next;
    logic [SLOT_W-1:0] bslot_reg, bslot_next;
    logic              key_used_reg, key_used_next;
    logic [CNT_W-1:0]  key_cnt_reg, key_cnt_next;
    logic [LEN_W-1:0]  key_len_reg, key_len_next;
    logic [LEN_W-1:0]  b_len_reg, b_len_next;

    logic [ENTRIES-1:0] used_reg, used_next;
    logic [CNT_W-1:0]   cnt_reg [ENTRIES];
    logic [CNT_W-1:0]   cnt_next [ENTRIES];
    logic [LEN_W-1:0]   len_reg [ENTRIES];
    logic [LEN_W-1:0]   len_next [ENTRIES];
    logic [SLOT_W-1:0]  order_reg [ENTRIES];
    logic [SLOT_W-1:0]  order_next [ENTRIES];

    logic pend_valid_reg, pend_valid_next;
    out_t pend_reg, pend_next;
    out_t rd_res_reg, rd_res_next;
    logic rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0] rd_hold_reg, rd_hold_next;

    logic m_valid_reg;
    out_t m_data_reg;

    // memory ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
    logic [7:0]        wr_data, rd_a_data, rd_b_data;

    // shared table reads
    logic [SLOT_W-1:0] meta_idx, ord_idx, ord_rd;
    logic              meta_used;
    logic [CNT_W-1:0]  meta_cnt;
    logic [LEN_W-1:0]  meta_len;

    logic              emit, out_free, dec, res;
    out_t              emit_data, entry;
    logic [SLOT_W-1:0] dec_b;
    logic [SLOT_W-1:0] slot4, free4;
    logic [SCNT_W-1:0] jm1;
    logic [LEN_W-1:0]  nmin;
    logic              rank_ok, rd_ok;

    wfc_word_mem u_mem (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    assign ord_rd    = order_reg[ord_idx];
    assign meta_used = used_reg[meta_idx];
    assign meta_cnt  = cnt_reg[meta_idx];
    assign meta_len  = len_reg[meta_idx];
    assign out_free  = !m_valid_reg || m_ready;
    assign slot4     = slot_reg[SLOT_W-1:0];
    assign free4     = free_reg[SLOT_W-1:0];
    assign jm1       = j_reg - SCNT_W'(1);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // next state and datapath control
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        wlen_next       = wlen_reg;
        k_next          = k_reg;
        slot_next       = slot_reg;
        free_next       = free_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        bslot_next      = bslot_reg;
        key_used_next   = key_used_reg;
        key_cnt_next    = key_cnt_reg;
        key_len_next    = key_len_reg;
        b_len_next      = b_len_reg;
        used_next       = used_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        order_next      = order_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rd_res_next     = rd_res_reg;
        rd_ok_next      = rd_ok_reg;
        rd_hold_next    = rd_hold_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_a_addr       = rd_hold_reg;
        rd_b_addr       = '0;
        meta_idx        = '0;
        ord_idx         = '0;
        s_ready         = 1'b0;
        emit            = 1'b0;
        emit_data       = '0;
        dec             = 1'b0;
        res             = 1'b0;
        dec_b           = bslot_reg;
        nmin            = '0;
        rank_ok         = 1'b0;
        rd_ok           = 1'b0;
        entry           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_data.op)
                        OP_CHAR: begin
                            if (int'(fill_reg) < WORD_LEN) begin
                                wr_en     = 1'b1;
                                wr_addr   = mem_addr(ROW_W'(BUF_ROW), fill_reg);
                                wr_data   = s_data.ch;
                                fill_next = fill_reg + LEN_W'(1);
                            end
                        end
                        OP_END: begin
                            fill_next = '0;
                            wlen_next = fill_reg;
                            if (fill_reg != '0 && fill_reg >= min_len_reg) begin
                                slot_next  = '0;
                                free_next  = SCNT_W'(ENTRIES);
                                state_next = ST_SRCH;
                            end
                        end
                        OP_REPORT: begin
                            fill_next = '0;
                            for (int e = 0; e < ENTRIES; e++) begin
                                order_next[e] = SLOT_W'(e);
                            end
                            i_next     = SCNT_W'(1);
                            state_next = ST_SORT_OUT;
                        end
                        OP_READ: begin
                            rank_ok   = int'(s_data.rank_in) < ENTRIES;
                            ord_idx   = SLOT_W'(s_data.rank_in);
                            meta_idx  = ord_rd;
                            rd_ok     = rank_ok && meta_used;
                            rd_a_addr = mem_addr(ROW_W'(ord_rd), LEN_W'(s_data.position));
                            rd_hold_next = rd_a_addr;
                            rd_ok_next   = rd_ok && (LEN_W'(s_data.position) < meta_len);
                            rd_res_next.kind        = KIND_CHAR;
                            rd_res_next.rank        = s_data.rank_in;
                            rd_res_next.count       = rd_ok ? meta_cnt : '0;
                            rd_res_next.word_length = rd_ok ? meta_len : '0;
                            rd_res_next.char_out    = '0;
                            rd_res_next.last        = 1'b1;
                            state_next = ST_RDOUT;
                        end
                        OP_CLEAR: begin
                            fill_next = '0;
                            used_next = '0;
                            for (int e = 0; e < ENTRIES; e++) begin
                                cnt_next[e]   = '0;
                                len_next[e]   = '0;
                                order_next[e] = SLOT_W'(e);
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // scan slots for an equal word, noting the first free one
            ST_SRCH: begin
                meta_idx = slot4;
                if (int'(slot_reg) == ENTRIES) begin
                    if (int'(free_reg) != ENTRIES) begin
                        k_next     = '0;
                        state_next = ST_CPRD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (meta_used && meta_len == wlen_reg) begin
                    k_next     = '0;
                    state_next = ST_SRD;
                end else begin
                    if (!meta_used && int'(free_reg) == ENTRIES) begin
                        free_next = slot_reg;
                    end
                    slot_next = slot_reg + SCNT_W'(1);
                end
            end

            ST_SRD: begin
                rd_a_addr  = mem_addr(ROW_W'(slot4), k_reg);
                rd_b_addr  = mem_addr(ROW_W'(BUF_ROW), k_reg);
                state_next = ST_SCHK;
            end

            ST_SCHK: begin
                meta_idx = slot4;
                if (rd_a_data != rd_b_data) begin
                    slot_next  = slot_reg + SCNT_W'(1);
                    state_next = ST_SRCH;
                end else if ((k_reg + LEN_W'(1)) == wlen_reg) begin
                    cnt_next[slot4] = (meta_cnt == CNT_MAX) ? meta_cnt
                                                            : meta_cnt + CNT_W'(1);
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + LEN_W'(1);
                    state_next = ST_SRD;
                end
            end

            // copy the new word into the free slot
            ST_CPRD: begin
                rd_b_addr  = mem_addr(ROW_W'(BUF_ROW), k_reg);
                state_next = ST_CPWR;
            end

            ST_CPWR: begin
                wr_en   = 1'b1;
                wr_addr = mem_addr(ROW_W'(free4), k_reg);
                wr_data = rd_b_data;
                if ((k_reg + LEN_W'(1)) == wlen_reg) begin
                    len_next[free4] = wlen_reg;
                    cnt_next[free4] = CNT_W'(1);
                    used_next[free4] = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + LEN_W'(1);
                    state_next = ST_CPRD;
                end
            end

            // pick up the next key of the insertion sort
            ST_SORT_OUT: begin
                ord_idx       = i_reg[SLOT_W-1:0];
                meta_idx      = ord_rd;
                key_next      = ord_rd;
                key_used_next = meta_used;
                key_cnt_next  = meta_cnt;
                key_len_next  = meta_len;
                j_next        = i_reg;
                state_next    = ST_SCMP;
            end

            // compare key with the slot just above it
            ST_SCMP: begin
                ord_idx    = jm1[SLOT_W-1:0];
                meta_idx   = ord_rd;
                dec_b      = ord_rd;
                bslot_next = ord_rd;
                b_len_next = meta_len;
                nmin       = (key_len_reg < meta_len) ? key_len_reg : meta_len;
                if (key_used_reg != meta_used) begin
                    dec = 1'b1;
                    res = key_used_reg;
                end else if (!key_used_reg) begin
                    dec = 1'b1;
                    res = key_reg < ord_rd;
                end else if (key_cnt_reg != meta_cnt) begin
                    dec = 1'b1;
                    res = key_cnt_reg > meta_cnt;
                end else if (nmin == '0) begin
                    dec = 1'b1;
                    res = (key_len_reg != meta_len) ? (key_len_reg < meta_len)
                                                    : (key_reg < ord_rd);
                end else begin
                    wlen_next  = nmin;
                    k_next     = '0;
                    state_next = ST_CRD;
                end
            end

            ST_CRD: begin
                rd_a_addr  = mem_addr(ROW_W'(key_reg), k_reg);
                rd_b_addr  = mem_addr(ROW_W'(bslot_reg), k_reg);
                state_next = ST_CCHK;
            end

            ST_CCHK: begin
                if (rd_a_data != rd_b_data) begin
                    dec = 1'b1;
                    res = rd_a_data < rd_b_data;
                end else if ((k_reg + LEN_W'(1)) == wlen_reg) begin
                    dec = 1'b1;
                    res = (key_len_reg != b_len_reg) ? (key_len_reg < b_len_reg)
                                                     : (key_reg < bslot_reg);
                end else begin
                    k_next     = k_reg + LEN_W'(1);
                    state_next = ST_CRD;
                end
            end

            // walk the ranks, holding one entry back to mark the last
            ST_RPT: begin
                ord_idx  = i_reg[SLOT_W-1:0];
                meta_idx = ord_rd;
                entry.kind        = KIND_ENTRY;
                entry.rank        = 4'(i_reg);
                entry.count       = meta_cnt;
                entry.word_length = meta_len;
                if (int'(i_reg) == ENTRIES || int'(i_reg) == MAX_RESULTS) begin
                    state_next = ST_RFIN;
                end else if (meta_used && meta_cnt >= min_cnt_reg) begin
                    if (!pend_valid_reg) begin
                        pend_valid_next = 1'b1;
                        pend_next       = entry;
                        i_next          = i_reg + SCNT_W'(1);
                    end else if (out_free) begin
                        emit      = 1'b1;
                        emit_data = pend_reg;
                        pend_next = entry;
                        i_next    = i_reg + SCNT_W'(1);
                    end
                end else begin
                    i_next = i_reg + SCNT_W'(1);
                end
            end

            ST_RFIN: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (pend_valid_reg) begin
                        emit_data      = pend_reg;
                        emit_data.last = 1'b1;
                    end else begin
                        emit_data.kind = KIND_NONE;
                        emit_data.last = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_RDOUT: begin
                if (out_free) begin
                    emit               = 1'b1;
                    emit_data          = rd_res_reg;
                    emit_data.char_out = rd_ok_reg ? rd_a_data : '0;
                    state_next         = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // insertion step once a comparison has settled
        if (dec) begin
            if (res) begin
                order_next[j_reg[SLOT_W-1:0]] = dec_b;
                j_next = jm1;
                if (jm1 == '0) begin
                    order_next[0] = key_reg;
                end
            end else begin
                order_next[j_reg[SLOT_W-1:0]] = key_reg;
            end
            if (!res || jm1 != '0) begin
                state_next = ST_SCMP;
            end
            if (!res || jm1 == '0) begin
                if (int'(i_reg) == ENTRIES - 1) begin
                    i_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_RPT;
                end else begin
                    i_next     = i_reg + SCNT_W'(1);
                    state_next = ST_SORT_OUT;
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            min_len_reg    <= LEN_W'(1);
            min_cnt_reg    <= CNT_W'(1);
            fill_reg       <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int e = 0; e < ENTRIES; e++) begin
                cnt_reg[e]   <= '0;
                len_reg[e]   <= '0;
                order_reg[e] <= SLOT_W'(e);
            end
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            used_reg       <= used_next;
            cnt_reg        <= cnt_next;
            len_reg        <= len_next;
            order_reg      <= order_next;
            pend_valid_reg <= pend_valid_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // configuration transfer
            if (cfg_valid) begin
                if (cfg_index == CFG_MIN_LENGTH) begin
                    min_len_reg <= cfg_data[LEN_W-1:0];
                end else if (cfg_index == CFG_MIN_COUNT) begin
                    min_cnt_reg <= cfg_data[CNT_W-1:0];
                end
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        wlen_reg     <= wlen_next;
        k_reg        <= k_next;
        slot_reg     <= slot_next;
        free_reg     <= free_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        key_reg      <= key_next;
        bslot_reg    <= bslot_next;
        key_used_reg <= key_used_next;
        key_cnt_reg  <= key_cnt_next;
        key_len_reg  <= key_len_next;
        b_len_reg    <= b_len_next;
        pend_reg     <= pend_next;
        rd_res_reg   <= rd_res_next;
        rd_ok_reg    <= rd_ok_next;
        rd_hold_reg  <= rd_hold_next;
        if (emit) begin
            m_data_reg <= emit_data;
        end
    end

    // word fill never runs past the buffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= WORD_LEN)
        else $error("word fill beyond buffer");

    // a character read is always a single, final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_CHAR |-> m_data.last)
        else $error("character read not marked last");

    // clearing frees every slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.op == OP_CLEAR |=> used_reg == '0)
        else $error("slots still used after clear");

endmodule

// ===== design/wfc_word_mem.sv =====
module wfc_word_mem (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [wfc_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic [wfc_pkg::ADDR_W-1:0] rd_a_addr,
    input  logic [wfc_pkg::ADDR_W-1:0] rd_b_addr,
    output logic [7:0]                rd_a_data,
    output logic [7:0]                rd_b_data
);
    import wfc_pkg::*;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule
